// ----- rtl/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types, constants and the quarter-step phase table of the stepper
// microstep sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int LEVEL_BITS_DEF = 8;

    localparam int CMD_BITS       = 2;
    localparam int TIME_IN_BITS   = 32;
    localparam int PERIOD_BITS    = 31;
    localparam int SUBSTEP_BITS   = 32;
    localparam int PHASE_BITS     = 4;
    localparam int MODE_BITS      = 2;
    localparam int FSPR_BITS      = 16;
    localparam int DIVR_BITS      = FSPR_BITS + 2;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_MODE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FSPR       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_LEVEL = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MID_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LEVEL  = 3'd4;

    localparam logic [MODE_BITS-1:0]     MODE_RST    = 2'd0;
    localparam logic [MODE_BITS-1:0]     MODE_QUARTER = 2'd2;
    localparam logic [FSPR_BITS-1:0]     FSPR_RST    = 16'd200;
    localparam logic [CFG_DATA_BITS-1:0] HIGH_RST    = 16'd255;
    localparam logic [CFG_DATA_BITS-1:0] MID_RST     = 16'd192;
    localparam logic [CFG_DATA_BITS-1:0] LOW_RST     = 16'd0;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_ZERO  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        LVL_LOW  = 2'd0,
        LVL_HIGH = 2'd1,
        LVL_MID  = 2'd2
    } t_lvl_code;

    typedef struct packed {
        t_lvl_code a1;
        t_lvl_code a2;
        t_lvl_code b1;
        t_lvl_code b2;
    } t_pin_codes;

    typedef struct packed {
        logic start;
        logic stop;
        logic load_delay;
        logic tick_cap;
        logic tick_adv;
        logic emit_tick;
        logic sweep_init;
        logic emit_sweep;
    } t_dp_cmd;

    typedef struct packed {
        logic sub_zero;
        logic running;
        logic div_done;
        logic tick_due;
        logic at_target;
        logic out_free;
        logic sweep_zero;
    } t_dp_sts;

    function automatic t_pin_codes stp_pin_codes(input logic [PHASE_BITS-1:0] q);
        t_pin_codes c;
        case (q)
            4'd0:    c = '{LVL_HIGH, LVL_LOW,  LVL_HIGH, LVL_LOW};
            4'd1:    c = '{LVL_HIGH, LVL_MID,  LVL_HIGH, LVL_LOW};
            4'd2:    c = '{LVL_LOW,  LVL_LOW,  LVL_HIGH, LVL_LOW};
            4'd3:    c = '{LVL_LOW,  LVL_MID,  LVL_HIGH, LVL_LOW};
            4'd4:    c = '{LVL_LOW,  LVL_HIGH, LVL_HIGH, LVL_LOW};
            4'd5:    c = '{LVL_LOW,  LVL_HIGH, LVL_HIGH, LVL_MID};
            4'd6:    c = '{LVL_LOW,  LVL_HIGH, LVL_LOW,  LVL_LOW};
            4'd7:    c = '{LVL_LOW,  LVL_HIGH, LVL_LOW,  LVL_MID};
            4'd8:    c = '{LVL_LOW,  LVL_HIGH, LVL_LOW,  LVL_HIGH};
            4'd9:    c = '{LVL_LOW,  LVL_MID,  LVL_LOW,  LVL_HIGH};
            4'd10:   c = '{LVL_LOW,  LVL_LOW,  LVL_LOW,  LVL_HIGH};
            4'd11:   c = '{LVL_HIGH, LVL_MID,  LVL_LOW,  LVL_HIGH};
            4'd12:   c = '{LVL_HIGH, LVL_LOW,  LVL_LOW,  LVL_HIGH};
            4'd13:   c = '{LVL_HIGH, LVL_LOW,  LVL_LOW,  LVL_MID};
            4'd14:   c = '{LVL_HIGH, LVL_LOW,  LVL_LOW,  LVL_LOW};
            4'd15:   c = '{LVL_HIGH, LVL_LOW,  LVL_HIGH, LVL_MID};
            default: c = '{LVL_LOW,  LVL_LOW,  LVL_LOW,  LVL_LOW};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/stp_ifs.sv -----
// ----------------------------------------------------------------------------
// stp_ifs
// Valid/ready channel interfaces: command input, drive output, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_in_if;
    import stp_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [CMD_BITS-1:0]            cmd;
    logic [TIME_IN_BITS-1:0]        time_now;
    logic [PERIOD_BITS-1:0]         move_period;
    logic signed [SUBSTEP_BITS-1:0] move_substeps;

    modport source (output valid, cmd, time_now, move_period, move_substeps, input ready);
    modport sink   (input valid, cmd, time_now, move_period, move_substeps, output ready);
endinterface

interface stp_out_if #(
    parameter int LEVEL_BITS = stp_pkg::LEVEL_BITS_DEF
);
    import stp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] drive_a1;
    logic [LEVEL_BITS-1:0] drive_a2;
    logic [LEVEL_BITS-1:0] drive_b1;
    logic [LEVEL_BITS-1:0] drive_b2;
    logic [PHASE_BITS-1:0] phase_now;
    logic                  last;

    modport source (output valid, drive_a1, drive_a2, drive_b1, drive_b2, phase_now, last,
                    input ready);
    modport sink   (input valid, drive_a1, drive_a2, drive_b1, drive_b2, phase_now, last,
                    output ready);
endinterface

interface stp_cfg_if;
    import stp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/stp_div.sv -----
// ----------------------------------------------------------------------------
// stp_div
// Restoring divider, one quotient bit per cycle, for the substep interval.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [stp_pkg::PERIOD_BITS-1:0] i_dividend,
    input  wire logic [stp_pkg::DIVR_BITS-1:0]   i_divisor,
    output logic                                 o_done,
    output logic [stp_pkg::PERIOD_BITS-1:0]      o_quotient
);
    import stp_pkg::*;

    localparam int CNT_BITS = $clog2(PERIOD_BITS + 1);

    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_done;
    logic [DIVR_BITS-1:0]   r_rem;
    logic [DIVR_BITS-1:0]   r_divisor;
    logic [PERIOD_BITS-1:0] r_quo;

    logic [DIVR_BITS:0]     w_trial;
    logic [DIVR_BITS:0]     w_diff;

    assign w_trial = {r_rem, r_quo[PERIOD_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_BITS'(PERIOD_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!w_diff[DIVR_BITS]) begin
                r_rem <= w_diff[DIVR_BITS-1:0];
                r_quo <= {r_quo[PERIOD_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DIVR_BITS-1:0];
                r_quo <= {r_quo[PERIOD_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- rtl/stp_dp.sv -----
// ----------------------------------------------------------------------------
// stp_dp
// Datapath: config registers, move state, tick timing, phase decode and the
// output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_dp #(
    parameter int TIME_BITS  = stp_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS = stp_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire stp_pkg::t_dp_cmd                        i_cmd,
    output stp_pkg::t_dp_sts                             o_sts,
    input  wire logic [stp_pkg::TIME_IN_BITS-1:0]        i_time_now,
    input  wire logic [stp_pkg::PERIOD_BITS-1:0]         i_move_period,
    input  wire logic signed [stp_pkg::SUBSTEP_BITS-1:0] i_move_substeps,
    stp_cfg_if.sink                                      i_cfg,
    stp_out_if.source                                    o_out
);
    import stp_pkg::*;

    logic [MODE_BITS-1:0]    r_step_mode;
    logic [FSPR_BITS-1:0]    r_fspr;
    logic [LEVEL_BITS-1:0]   r_high;
    logic [LEVEL_BITS-1:0]   r_mid;
    logic [LEVEL_BITS-1:0]   r_low;

    logic                    r_running;
    logic                    r_dir_neg;
    logic [SUBSTEP_BITS-1:0] r_remain;
    logic [PHASE_BITS-1:0]   r_cur_lo;
    logic [PHASE_BITS-1:0]   r_cur_phase;
    logic [TIME_BITS-1:0]    r_last_time;
    logic [TIME_BITS-1:0]    r_delay;
    logic [TIME_BITS-1:0]    r_now;
    logic [TIME_BITS-1:0]    r_diff;
    logic [PHASE_BITS-1:0]   r_sweep;
    logic                    r_div_zero;

    logic                    r_out_valid;
    logic [LEVEL_BITS-1:0]   r_a1;
    logic [LEVEL_BITS-1:0]   r_a2;
    logic [LEVEL_BITS-1:0]   r_b1;
    logic [LEVEL_BITS-1:0]   r_b2;
    logic [PHASE_BITS-1:0]   r_phase;
    logic                    r_last;

    logic [MODE_BITS-1:0]    w_sh;
    logic [PHASE_BITS-1:0]   w_mask;
    logic [DIVR_BITS-1:0]    w_divisor;
    logic [TIME_BITS-1:0]    w_now;
    logic [SUBSTEP_BITS-1:0] w_abs;
    logic                    w_div_done;
    logic [PERIOD_BITS-1:0]  w_quo;
    logic                    w_emit;
    logic [PHASE_BITS-1:0]   w_phase;
    logic [PHASE_BITS-1:0]   w_q;
    t_pin_codes              w_codes;
    logic                    w_out_free;

    function automatic logic [LEVEL_BITS-1:0] level_of(input t_lvl_code c,
                                                       input logic [LEVEL_BITS-1:0] hi,
                                                       input logic [LEVEL_BITS-1:0] md,
                                                       input logic [LEVEL_BITS-1:0] lo);
        logic [LEVEL_BITS-1:0] v;
        case (c)
            LVL_HIGH: v = hi;
            LVL_MID:  v = md;
            default:  v = lo;
        endcase
        return v;
    endfunction

    assign w_sh      = (r_step_mode >= MODE_QUARTER) ? MODE_QUARTER : r_step_mode;
    assign w_mask    = PHASE_BITS'((5'd4 << w_sh) - 5'd1);
    assign w_divisor = {2'b00, r_fspr} << w_sh;
    assign w_now     = TIME_BITS'({32'd0, i_time_now});
    assign w_abs     = i_move_substeps[SUBSTEP_BITS-1] ? (~i_move_substeps + 1'b1)
                                                       : i_move_substeps;

    assign w_emit  = i_cmd.emit_tick | i_cmd.emit_sweep;
    assign w_phase = i_cmd.emit_sweep ? r_sweep : (r_cur_lo & w_mask);
    assign w_q     = PHASE_BITS'(w_phase << (MODE_QUARTER - w_sh));
    assign w_codes = stp_pin_codes(w_q);

    assign w_out_free = !r_out_valid || o_out.ready;

    stp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (i_move_period),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_mode <= MODE_RST;
            r_fspr      <= FSPR_RST;
            r_high      <= LEVEL_BITS'(HIGH_RST);
            r_mid       <= LEVEL_BITS'(MID_RST);
            r_low       <= LEVEL_BITS'(LOW_RST);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_STEP_MODE:  r_step_mode <= i_cfg.data[MODE_BITS-1:0];
                CFG_FSPR:       r_fspr      <= i_cfg.data[FSPR_BITS-1:0];
                CFG_HIGH_LEVEL: r_high      <= LEVEL_BITS'(i_cfg.data);
                CFG_MID_LEVEL:  r_mid       <= LEVEL_BITS'(i_cfg.data);
                CFG_LOW_LEVEL:  r_low       <= LEVEL_BITS'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // move state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_dir_neg   <= 1'b0;
            r_remain    <= '0;
            r_cur_lo    <= '0;
            r_cur_phase <= '0;
            r_last_time <= '0;
            r_delay     <= '0;
        end else begin
            if (i_cmd.stop) begin
                r_running <= 1'b0;
            end
            if (i_cmd.start) begin
                r_running   <= 1'b1;
                r_dir_neg   <= i_move_substeps[SUBSTEP_BITS-1];
                r_remain    <= w_abs;
                r_cur_lo    <= r_cur_phase;
                r_last_time <= w_now;
            end
            if (i_cmd.load_delay) begin
                r_delay <= r_div_zero ? '1 : TIME_BITS'({33'd0, w_quo});
            end
            if (i_cmd.tick_adv) begin
                r_last_time <= r_now;
                if (r_remain == '0) begin
                    r_running <= 1'b0;
                end else begin
                    r_remain <= r_remain - 1'b1;
                    r_cur_lo <= r_dir_neg ? (r_cur_lo - 1'b1) : (r_cur_lo + 1'b1);
                end
            end
            if (w_emit) begin
                r_cur_phase <= w_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_div_zero <= (r_fspr == '0);
        end
        if (i_cmd.tick_cap) begin
            r_now  <= w_now;
            r_diff <= w_now - r_last_time;
        end
        if (i_cmd.sweep_init) begin
            r_sweep <= w_mask;
        end else if (i_cmd.emit_sweep) begin
            r_sweep <= r_sweep - 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_a1    <= level_of(w_codes.a1, r_high, r_mid, r_low);
            r_a2    <= level_of(w_codes.a2, r_high, r_mid, r_low);
            r_b1    <= level_of(w_codes.b1, r_high, r_mid, r_low);
            r_b2    <= level_of(w_codes.b2, r_high, r_mid, r_low);
            r_phase <= w_phase;
            r_last  <= i_cmd.emit_tick | (r_sweep == '0);
        end
    end

    assign i_cfg.ready     = 1'b1;

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_a1  = r_a1;
    assign o_out.drive_a2  = r_a2;
    assign o_out.drive_b1  = r_b1;
    assign o_out.drive_b2  = r_b2;
    assign o_out.phase_now = r_phase;
    assign o_out.last      = r_last;

    assign o_sts.sub_zero   = (i_move_substeps == '0);
    assign o_sts.running    = r_running;
    assign o_sts.div_done   = w_div_done;
    assign o_sts.tick_due   = (r_diff >= r_delay);
    assign o_sts.at_target  = (r_remain == '0);
    assign o_sts.out_free   = w_out_free;
    assign o_sts.sweep_zero = (r_sweep == '0);

endmodule

`default_nettype wire

// ----- rtl/stp_ctrl.sv -----
// ----------------------------------------------------------------------------
// stp_ctrl
// Sequencing state machine: decodes each command word and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [stp_pkg::CMD_BITS-1:0] i_in_cmd,
    output logic                              o_in_ready,
    input  wire stp_pkg::t_dp_sts             i_sts,
    output stp_pkg::t_dp_cmd                  o_cmd
);
    import stp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_TCMP,
        S_TEMIT,
        S_SWEEP
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_ready;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    case (t_cmd'(i_in_cmd))
                        CMD_START: begin
                            if (i_sts.sub_zero) begin
                                w_cmd.stop = 1'b1;
                            end else begin
                                w_cmd.start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                        CMD_STOP: begin
                            w_cmd.stop = 1'b1;
                        end
                        CMD_ZERO: begin
                            w_cmd.sweep_init = 1'b1;
                            n_state          = S_SWEEP;
                        end
                        CMD_TICK: begin
                            if (i_sts.running) begin
                                w_cmd.tick_cap = 1'b1;
                                n_state        = S_TCMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    w_cmd.load_delay = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_TCMP: begin
                if (!i_sts.tick_due) begin
                    n_state = S_IDLE;
                end else begin
                    w_cmd.tick_adv = 1'b1;
                    n_state        = i_sts.at_target ? S_IDLE : S_TEMIT;
                end
            end
            S_TEMIT: begin
                if (i_sts.out_free) begin
                    w_cmd.emit_tick = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (i_sts.out_free) begin
                    w_cmd.emit_sweep = 1'b1;
                    if (i_sts.sweep_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = w_cmd;

endmodule

`default_nettype wire

// ----- rtl/stepper_microstep_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// stepper_microstep_sequencer_top
// Two-coil stepper sequencer for full, half and quarter stepping.
// ----------------------------------------------------------------------------
// Handles one command word at a time. A tick that is due advances a step and
// sends the step word to the output register, or ends the move at its target.
// A start with nonzero substeps waits for the substep interval from a
// restoring divider that produces one quotient bit per cycle over the 31-bit
// period. A zero sweep emits one drive word per phase (4, 8 or 16). The next
// command word is taken while the last drive word still waits in the output
// register; a stalled output holds the sweep or tick back. Config writes are
// always taken and apply at once.
`default_nettype none

module stepper_microstep_sequencer_top #(
    parameter int TIME_BITS  = stp_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS = stp_pkg::LEVEL_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stp_in_if.sink    i_in,
    stp_cfg_if.sink   i_cfg,
    stp_out_if.source o_out
);
    import stp_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    stp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    stp_dp #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_time_now      (i_in.time_now),
        .i_move_period   (i_in.move_period),
        .i_move_substeps (i_in.move_substeps),
        .i_cfg           (i_cfg),
        .o_out           (o_out)
    );

endmodule

`default_nettype wire
